// ===== rtl/core/rope_pkg.sv =====
// Shared constants, register codes and arithmetic helpers for the rotary position embedding core.
`timescale 1ns / 1ps

package rope_pkg;

  // Fixed-point formats of the frequency path.
  localparam int STEP_BITS = 25;
  localparam int FRAC_BITS = 20;
  localparam int FREQ_BITS = 26;
  localparam int CFG_INDEX_BITS = 2;

  // One turn divided by two pi, unsigned Q0.32.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // Odd Taylor coefficients of sin(pi/2 * x), Q.30.
  localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C3 = 32'sd693598670;
  localparam logic signed [31:0] SIN_C5 = 32'sd85569313;
  localparam logic signed [31:0] SIN_C7 = 32'sd5026997;
  localparam logic signed [31:0] SIN_C9 = 32'sd172272;

  localparam logic signed [STEP_BITS-1:0] FREQ_STEP_RESET = -25'sd217706;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_POSITION_OFFSET = 2'd0,
    CFG_FREQ_STEP_LOG2  = 2'd1
  } cfg_index_t;

  typedef logic [FRAC_BITS:0][31:0] root_tab_t;

  // Floored integer square root, evaluated at elaboration only.
  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [31:0] res;
    logic [31:0] trial;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) begin
        res = trial;
      end
    end
    return res;
  endfunction

  // Table of 2^(2^-j) in Q2.30 by repeated square roots of 2.0.
  function automatic root_tab_t build_roots();
    root_tab_t t;
    t[0] = 32'h8000_0000;
    for (int j = 1; j <= FRAC_BITS; j++) begin
      t[j] = isqrt64({t[j-1], 30'b0} >> 0);
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

  // Sign-magnitude Q.30 product with rounding half up on the magnitude.
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic [30:0] b);
    logic [31:0] ua;
    logic [63:0] prod;
    logic [31:0] r;
    ua = a[31] ? (~a + 32'd1) : a;
    prod = 64'(ua) * 64'(b) + 64'd536870912;
    r = prod[61:30];
    return a[31] ? $signed(~r + 32'd1) : $signed(r);
  endfunction

endpackage

// ===== rtl/core/rotary_position_embedding_core.sv =====
// Top level of the rotary position embedding core: a fully pipelined rotation of one pair.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready   | token_index, pair_index, first_value,
//          |           |                       | second_value
//  output  | out       | out_valid / out_ready | rotated_first, rotated_second
//  config  | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pair enters per cycle while in_ready is high; each transfer passes 34 register stages
// before its result is offered. The depth is set by the twenty root multiplies of the
// frequency and the six polynomial steps of sin/cos.
// All stages move together whenever the output register is empty or being taken, so a stall
// holds every stage in place. Reset (synchronous, active high) clears the valid bits and
// restores the register defaults. The configuration port is always ready.

module rotary_position_embedding_core
  import rope_pkg::*;
#(
  parameter int VALUE_BITS      = 16,
  parameter int POSITION_BITS   = 20,
  parameter int PAIR_INDEX_BITS = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [POSITION_BITS-1:0]          token_index,
  input  logic [PAIR_INDEX_BITS-1:0]        pair_index,
  input  logic signed [VALUE_BITS-1:0]      first_value,
  input  logic signed [VALUE_BITS-1:0]      second_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [VALUE_BITS-1:0]      rotated_first,
  output logic signed [VALUE_BITS-1:0]      rotated_second,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
  input  logic [STEP_BITS-1:0]              cfg_data
);

  // Stage numbers.
  localparam int S_SPLIT = 1;
  localparam int S_FREQ  = FRAC_BITS + 2;
  localparam int S_PROD  = S_FREQ + 1;
  localparam int S_TURN  = S_PROD + 1;
  localparam int S_PHASE = S_TURN + 1;
  localparam int S_SQ    = S_PHASE + 1;
  localparam int S_SIN   = S_SQ + 5;
  localparam int S_MUL   = S_SIN + 1;
  localparam int S_OUT   = S_MUL + 1;
  localparam int NSTAGE  = S_OUT + 1;

  // Derived widths.
  localparam int POS_W  = POSITION_BITS + 1;
  localparam int EXP_W  = PAIR_INDEX_BITS + STEP_BITS + 1;
  localparam int K_W    = EXP_W - FRAC_BITS + 1;
  localparam int PROD_W = POS_W + FREQ_BITS;
  localparam int SC_W   = 18;
  localparam int MP_W   = VALUE_BITS + SC_W;
  localparam int SUM_W  = MP_W + 1;
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(64'sd1 <<< (VALUE_BITS - 1));

  typedef struct packed {
    logic [POS_W-1:0]             pos;
    logic signed [VALUE_BITS-1:0] x1;
    logic signed [VALUE_BITS-1:0] x2;
  } carry_t;

  typedef struct packed {
    logic                 sat;
    logic [K_W-1:0]       k;
    logic [FRAC_BITS-1:0] r;
  } split_t;

  // Configuration registers.
  logic [POSITION_BITS-1:0]    position_offset;
  logic signed [STEP_BITS-1:0] freq_step_log2;

  // Pipeline registers.
  logic [NSTAGE-1:0]           vld;
  carry_t                      car   [0:S_MUL-1];
  logic signed [EXP_W-1:0]     expo;
  split_t                      fsp   [S_SPLIT:S_FREQ-1];
  logic [31:0]                 mstg  [1:FRAC_BITS];
  logic [FREQ_BITS-1:0]        freq;
  logic [63:0]                 prod;
  logic [31:0]                 hprod;
  logic [53:0]                 lprod;
  logic [1:0]                  quad  [S_PHASE:S_MUL-1];
  logic [16:0]                 u_s;
  logic [16:0]                 u_c;
  logic [30:0]                 xs    [S_SQ:S_SIN-1];
  logic [30:0]                 xc    [S_SQ:S_SIN-1];
  logic [30:0]                 x2s   [S_SQ:S_SIN-2];
  logic [30:0]                 x2c   [S_SQ:S_SIN-2];
  logic signed [31:0]          ps    [1:4];
  logic signed [31:0]          pc    [1:4];
  logic [16:0]                 s0;
  logic [16:0]                 c0;
  logic signed [MP_W-1:0]      pa;
  logic signed [MP_W-1:0]      pb;
  logic signed [MP_W-1:0]      pc_m;
  logic signed [MP_W-1:0]      pd;

  // Combinational helpers.
  logic                        adv;
  logic [EXP_W-1:0]            mag;
  logic [K_W-1:0]              k_raw;
  split_t                      split_next;
  logic [31:0]                 m_src [1:FRAC_BITS];
  logic [63:0]                 m_prd [1:FRAC_BITS];
  logic [31:0]                 m_next [1:FRAC_BITS];
  logic [K_W-1:0]              shift;
  logic [63:0]                 f_wide;
  logic [FREQ_BITS-1:0]        freq_next;
  logic [55:0]                 acc;
  logic signed [31:0]          sv_s;
  logic signed [31:0]          sv_c;
  logic [16:0]                 s0_next;
  logic [16:0]                 c0_next;
  logic signed [SC_W-1:0]      sn;
  logic signed [SC_W-1:0]      cs;
  logic signed [SUM_W-1:0]     sum_a;
  logic signed [SUM_W-1:0]     sum_b;
  logic signed [SUM_W-1:0]     rnd_a;
  logic signed [SUM_W-1:0]     rnd_b;

  assign adv       = !vld[NSTAGE-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTAGE-1];
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_offset <= '0;
      freq_step_log2  <= FREQ_STEP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_POSITION_OFFSET) begin
        position_offset <= cfg_data[POSITION_BITS-1:0];
      end else if (cfg_index == CFG_FREQ_STEP_LOG2) begin
        freq_step_log2 <= $signed(cfg_data);
      end
    end
  end

  // Split the exponent into a whole shift and a positive fraction.
  always_comb begin
    mag   = EXP_W'(-expo);
    k_raw = K_W'(mag >> FRAC_BITS);
    split_next.sat = !expo[EXP_W-1];
    if (mag[FRAC_BITS-1:0] != '0) begin
      split_next.k = k_raw + K_W'(1);
      split_next.r = FRAC_BITS'(~mag[FRAC_BITS-1:0] + FRAC_BITS'(1));
    end else begin
      split_next.k = k_raw;
      split_next.r = '0;
    end
  end

  // One root multiply per stage, selected by one bit of the fraction.
  always_comb begin
    for (int j = 1; j <= FRAC_BITS; j++) begin
      m_src[j]  = (j == 1) ? 32'h4000_0000 : mstg[(j == 1) ? 1 : j - 1];
      m_prd[j]  = 64'(m_src[j]) * 64'(ROOT_TAB[j]) + 64'd536870912;
      m_next[j] = fsp[j].r[FRAC_BITS-j] ? m_prd[j][61:30] : m_src[j];
    end
  end

  // Final shift of the mantissa to Q1.24 with rounding.
  always_comb begin
    shift  = fsp[S_FREQ-1].k + K_W'(6);
    f_wide = (64'(mstg[FRAC_BITS]) + (64'd1 << (shift[5:0] - 6'd1))) >> shift[5:0];
    if (fsp[S_FREQ-1].sat) begin
      freq_next = FREQ_BITS'(1) << 24;
    end else if (shift >= K_W'(62)) begin
      freq_next = '0;
    end else begin
      freq_next = f_wide[FREQ_BITS-1:0];
    end
  end

  // Phase sum kept modulo one turn.
  assign acc = {hprod, 24'b0} + 56'(lprod);

  // Final polynomial product, clamp and rounding to Q1.15.
  always_comb begin
    sv_s = mul_q30(ps[4], xs[S_SIN-1]);
    sv_c = mul_q30(pc[4], xc[S_SIN-1]);
    if (sv_s[31]) begin
      s0_next = '0;
    end else if (sv_s > 32'sd1073741824) begin
      s0_next = 17'd32768;
    end else begin
      s0_next = 17'((sv_s + 32'sd16384) >>> 15);
    end
    if (sv_c[31]) begin
      c0_next = '0;
    end else if (sv_c > 32'sd1073741824) begin
      c0_next = 17'd32768;
    end else begin
      c0_next = 17'((sv_c + 32'sd16384) >>> 15);
    end
  end

  // Quadrant symmetries.
  always_comb begin
    case (quad[S_SIN])
      2'd0: begin
        sn = $signed(SC_W'(s0));
        cs = $signed(SC_W'(c0));
      end
      2'd1: begin
        sn = $signed(SC_W'(c0));
        cs = -$signed(SC_W'(s0));
      end
      2'd2: begin
        sn = -$signed(SC_W'(s0));
        cs = -$signed(SC_W'(c0));
      end
      default: begin
        sn = -$signed(SC_W'(c0));
        cs = $signed(SC_W'(s0));
      end
    endcase
  end

  // Sums and rounding by 2^15 of both outputs; saturation follows in the output register.
  always_comb begin
    sum_a = SUM_W'(pa) - SUM_W'(pb);
    sum_b = SUM_W'(pc_m) + SUM_W'(pd);
    rnd_a = (sum_a + SUM_W'(16384)) >>> 15;
    rnd_b = (sum_b + SUM_W'(16384)) >>> 15;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      car[0].pos <= POS_W'(position_offset) + POS_W'(token_index);
      car[0].x1  <= first_value;
      car[0].x2  <= second_value;
      for (int s = 1; s < S_MUL; s++) begin
        car[s] <= car[s-1];
      end
      expo <= EXP_W'($signed({1'b0, pair_index}) * freq_step_log2);

      fsp[S_SPLIT] <= split_next;
      for (int s = S_SPLIT + 1; s < S_FREQ; s++) begin
        fsp[s] <= fsp[s-1];
      end
      for (int j = 1; j <= FRAC_BITS; j++) begin
        mstg[j] <= m_next[j];
      end

      freq  <= freq_next;
      prod  <= 64'(car[S_PROD-1].pos) * 64'(freq);
      hprod <= 32'(64'(prod[55:24]) * 64'(INV_TWO_PI));
      lprod <= 54'(prod[23:0]) * 54'(INV_TWO_PI);

      quad[S_PHASE] <= acc[55:54];
      u_s           <= 17'(acc[53:38]);
      u_c           <= 17'd65536 - 17'(acc[53:38]);
      for (int s = S_PHASE + 1; s < S_MUL; s++) begin
        quad[s] <= quad[s-1];
      end

      // The angle and its square travel beside the polynomial steps.
      xs[S_SQ]  <= {u_s, 14'b0};
      xc[S_SQ]  <= {u_c, 14'b0};
      x2s[S_SQ] <= 31'(mul_q30($signed({1'b0, u_s, 14'b0}), {u_s, 14'b0}));
      x2c[S_SQ] <= 31'(mul_q30($signed({1'b0, u_c, 14'b0}), {u_c, 14'b0}));
      for (int s = S_SQ + 1; s < S_SIN; s++) begin
        xs[s] <= xs[s-1];
        xc[s] <= xc[s-1];
      end
      for (int s = S_SQ + 1; s < S_SIN - 1; s++) begin
        x2s[s] <= x2s[s-1];
        x2c[s] <= x2c[s-1];
      end
      ps[1] <= mul_q30(SIN_C9, x2s[S_SQ]) - SIN_C7;
      pc[1] <= mul_q30(SIN_C9, x2c[S_SQ]) - SIN_C7;
      ps[2] <= mul_q30(ps[1], x2s[S_SQ+1]) + SIN_C5;
      pc[2] <= mul_q30(pc[1], x2c[S_SQ+1]) + SIN_C5;
      ps[3] <= mul_q30(ps[2], x2s[S_SQ+2]) - SIN_C3;
      pc[3] <= mul_q30(pc[2], x2c[S_SQ+2]) - SIN_C3;
      ps[4] <= mul_q30(ps[3], x2s[S_SQ+3]) + SIN_C1;
      pc[4] <= mul_q30(pc[3], x2c[S_SQ+3]) + SIN_C1;
      s0    <= s0_next;
      c0    <= c0_next;

      pa   <= MP_W'(car[S_MUL-1].x1 * cs);
      pb   <= MP_W'(car[S_MUL-1].x2 * sn);
      pc_m <= MP_W'(car[S_MUL-1].x1 * sn);
      pd   <= MP_W'(car[S_MUL-1].x2 * cs);

      if (rnd_a > OUT_MAX) begin
        rotated_first <= VALUE_BITS'(OUT_MAX);
      end else if (rnd_a < OUT_MIN) begin
        rotated_first <= VALUE_BITS'(OUT_MIN);
      end else begin
        rotated_first <= VALUE_BITS'(rnd_a);
      end
      if (rnd_b > OUT_MAX) begin
        rotated_second <= VALUE_BITS'(OUT_MAX);
      end else if (rnd_b < OUT_MIN) begin
        rotated_second <= VALUE_BITS'(OUT_MIN);
      end else begin
        rotated_second <= VALUE_BITS'(rnd_b);
      end
    end
  end

endmodule
